### hw/rtl/srht_pkg.sv
// ----------------------------------------------------------------------------
// srht_pkg
// Shared types and constants for the segment/rectangle hit test block.
// ----------------------------------------------------------------------------
package srht_pkg;

    // Default coordinate width for every field and clip register.
    localparam int COORD_WIDTH_DEF = 16;

    // Clip register indexes on the configuration port.
    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_BOTTOM = 2'd3
    } cfg_index_t;

    // Load enables for the four payload stages of the datapath.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

### hw/rtl/srht_datapath.sv
// ----------------------------------------------------------------------------
// srht_datapath
// Four-stage payload pipeline: endpoint ordering and x clipping, differences
// and special-case flags, cross products, and the final sign decision.
// ----------------------------------------------------------------------------
module srht_datapath #(
    parameter int COORD_WIDTH = srht_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  srht_pkg::stage_en_t           en,
    input  logic signed [COORD_WIDTH-1:0] clip_left,
    input  logic signed [COORD_WIDTH-1:0] clip_top,
    input  logic signed [COORD_WIDTH-1:0] clip_right,
    input  logic signed [COORD_WIDTH-1:0] clip_bottom,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic                          hit
);
    import srht_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;        // coordinate differences
    localparam int PW = 2 * W + 2;    // cross products
    localparam int SW = 2 * W + 3;    // sums of two products
    localparam int XW = PW - DW;      // sign extension of a difference

    // Stage 1: endpoints ordered by x, x span clipped.
    logic signed [W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, lo_reg, hi_reg;
    logic signed [W-1:0] x1_next, y1_next, x2_next, y2_next, lo_next, hi_next;
    logic                swap;

    always_comb
    begin
        swap    = start_x > end_x;
        x1_next = swap ? end_x   : start_x;
        y1_next = swap ? end_y   : start_y;
        x2_next = swap ? start_x : end_x;
        y2_next = swap ? start_y : end_y;
        lo_next = (x1_next < clip_left)  ? clip_left  : x1_next;
        hi_next = (x2_next > clip_right) ? clip_right : x2_next;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Stage 2: differences one bit wider than the coordinates, plus flags.
    logic signed [DW-1:0] d_reg, dy_reg, ylb_reg, ylt_reg, dlo_reg, dhi_reg;
    logic signed [DW-1:0] d_next, dy_next, ylb_next, ylt_next, dlo_next, dhi_next;
    logic                 empty2_reg, vert2_reg, vhit2_reg;
    logic                 empty2_next, vert2_next, vhit2_next;

    always_comb
    begin
        d_next   = $signed({x2_reg[W-1], x2_reg}) - $signed({x1_reg[W-1], x1_reg});
        dy_next  = $signed({y2_reg[W-1], y2_reg}) - $signed({y1_reg[W-1], y1_reg});
        ylb_next = $signed({y1_reg[W-1], y1_reg}) - $signed({clip_bottom[W-1], clip_bottom});
        ylt_next = $signed({y1_reg[W-1], y1_reg}) - $signed({clip_top[W-1], clip_top});
        dlo_next = $signed({lo_reg[W-1], lo_reg}) - $signed({x1_reg[W-1], x1_reg});
        dhi_next = $signed({hi_reg[W-1], hi_reg}) - $signed({x1_reg[W-1], x1_reg});
        empty2_next = (lo_reg > hi_reg) || (clip_top > clip_bottom);
        vert2_next  = x1_reg == x2_reg;
        vhit2_next  = ((y1_reg <= clip_bottom) || (y2_reg <= clip_bottom)) &&
                      ((y1_reg >= clip_top) || (y2_reg >= clip_top));
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            d_reg      <= d_next;
            dy_reg     <= dy_next;
            ylb_reg    <= ylb_next;
            ylt_reg    <= ylt_next;
            dlo_reg    <= dlo_next;
            dhi_reg    <= dhi_next;
            empty2_reg <= empty2_next;
            vert2_reg  <= vert2_next;
            vhit2_reg  <= vhit2_next;
        end
    end

    // Stage 3: the four cross products, each exact at full width.
    logic signed [PW-1:0] p_yb_reg, p_yt_reg, p_lo_reg, p_hi_reg;
    logic signed [PW-1:0] p_yb_next, p_yt_next, p_lo_next, p_hi_next;
    logic                 empty3_reg, vert3_reg, vhit3_reg;

    always_comb
    begin
        p_yb_next = $signed({{XW{ylb_reg[DW-1]}}, ylb_reg}) *
                    $signed({{XW{d_reg[DW-1]}}, d_reg});
        p_yt_next = $signed({{XW{ylt_reg[DW-1]}}, ylt_reg}) *
                    $signed({{XW{d_reg[DW-1]}}, d_reg});
        p_lo_next = $signed({{XW{dy_reg[DW-1]}}, dy_reg}) *
                    $signed({{XW{dlo_reg[DW-1]}}, dlo_reg});
        p_hi_next = $signed({{XW{dy_reg[DW-1]}}, dy_reg}) *
                    $signed({{XW{dhi_reg[DW-1]}}, dhi_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            p_yb_reg   <= p_yb_next;
            p_yt_reg   <= p_yt_next;
            p_lo_reg   <= p_lo_next;
            p_hi_reg   <= p_hi_next;
            empty3_reg <= empty2_reg;
            vert3_reg  <= vert2_reg;
            vhit3_reg  <= vhit2_reg;
        end
    end

    // Stage 4: the sign of d * (y(x) - c) at both clipped x ends, then the hit.
    logic signed [SW-1:0] e_lb, e_hb, e_lt, e_ht;
    logic                 hit_reg, hit_next;

    always_comb
    begin
        e_lb = $signed({p_yb_reg[PW-1], p_yb_reg}) + $signed({p_lo_reg[PW-1], p_lo_reg});
        e_hb = $signed({p_yb_reg[PW-1], p_yb_reg}) + $signed({p_hi_reg[PW-1], p_hi_reg});
        e_lt = $signed({p_yt_reg[PW-1], p_yt_reg}) + $signed({p_lo_reg[PW-1], p_lo_reg});
        e_ht = $signed({p_yt_reg[PW-1], p_yt_reg}) + $signed({p_hi_reg[PW-1], p_hi_reg});
        if (empty3_reg)
            hit_next = 1'b0;
        else if (vert3_reg)
            hit_next = vhit3_reg;
        else
            hit_next = (e_lb[SW-1] || (e_lb == '0) || e_hb[SW-1] || (e_hb == '0)) &&
                       (!e_lt[SW-1] || !e_ht[SW-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
            hit_reg <= hit_next;
    end

    assign hit = hit_reg;

endmodule

### hw/rtl/segment_rectangle_hit_test_unit.sv
// ----------------------------------------------------------------------------
// segment_rectangle_hit_test_unit
// Tests a line segment against a closed clip rectangle with exact integer
// cross-multiplication.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    start_x start_y end_x end_y
//   out      output     out_valid / out_stall  hit
//   cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// One segment enters per cycle while in_stall is low; its result is offered
// on out_valid once it has passed the four register stages of the datapath
// (order and clip, differences, products, sums and decision).
// Reset clears the stage valid bits and sets all clip registers to zero.
// A stall on the output holds the last stage; bubbles in front of it still
// fill, and in_stall rises only when every stage holds an item.
// ----------------------------------------------------------------------------
module segment_rectangle_hit_test_unit #(
    parameter int COORD_WIDTH = srht_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  srht_pkg::cfg_index_t          cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    // Segment input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    // Result output channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit
);
    import srht_pkg::*;

    // Clip rectangle registers; writes to them are always taken.
    logic signed [COORD_WIDTH-1:0] left_reg, top_reg, right_reg, bottom_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEFT:   left_reg   <= cfg_data;
                CFG_TOP:    top_reg    <= cfg_data;
                CFG_RIGHT:  right_reg  <= cfg_data;
                CFG_BOTTOM: bottom_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Stage valid bits and per-stage load conditions; a stage loads when it
    // is empty or when the stage after it loads.
    logic      v1_reg, v2_reg, v3_reg, v4_reg;
    logic      v1_next, v2_next, v3_next, v4_next;
    logic      ld1, ld2, ld3, ld4;
    stage_en_t en;

    always_comb
    begin
        ld4 = !v4_reg || !out_stall;
        ld3 = !v3_reg || ld4;
        ld2 = !v2_reg || ld3;
        ld1 = !v1_reg || ld2;
        v4_next = ld4 ? v3_reg   : v4_reg;
        v3_next = ld3 ? v2_reg   : v3_reg;
        v2_next = ld2 ? v1_reg   : v2_reg;
        v1_next = ld1 ? in_valid : v1_reg;
        en.s1 = ld1 && in_valid;
        en.s2 = ld2 && v1_reg;
        en.s3 = ld3 && v2_reg;
        en.s4 = ld4 && v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign in_stall  = !ld1;
    assign out_valid = v4_reg;

    // Payload pipeline.
    srht_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .en          (en),
        .clip_left   (left_reg),
        .clip_top    (top_reg),
        .clip_right  (right_reg),
        .clip_bottom (bottom_reg),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .hit         (hit)
    );

`ifndef SYNTHESIS
    // The input side only stalls when every stage is occupied.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled while the pipeline has a free stage");

    // An item moving into the last stage shows up as a result next cycle.
    a_advance_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && ld4) |=> out_valid)
        else $error("item lost on its way to the output stage");

    // A delivered result with nothing behind it leaves the output empty.
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !v3_reg) |=> !out_valid)
        else $error("result repeated after its transfer");
`endif

endmodule
